FILE: rtl/core/gnh_pkg.sv
// ----------------------------------------------------------------------------
// gnh_pkg
// Shared codes and types for the greedy next-hop neighbor table.
// ----------------------------------------------------------------------------
package gnh_pkg;

  localparam logic [2:0] CMD_ADD     = 3'd0;
  localparam logic [2:0] CMD_DELETE  = 3'd1;
  localparam logic [2:0] CMD_GET_POS = 3'd2;
  localparam logic [2:0] CMD_GET_VEL = 3'd3;
  localparam logic [2:0] CMD_IS_NBR  = 3'd4;
  localparam logic [2:0] CMD_NEXTHOP = 3'd5;
  localparam logic [2:0] CMD_PURGE   = 3'd6;
  localparam logic [2:0] CMD_CLEAR   = 3'd7;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  localparam logic [31:0] LIFETIME_RESET = 32'd2000;

  // Squared difference of two 24-bit signed values: 25-bit magnitude, 50-bit square.
  typedef logic [49:0] sq_t;
  // Sum of three squares.
  typedef logic [51:0] dist_t;

  typedef struct packed {
    logic        start;
    logic [24:0] a;
  } sq_req_t;

endpackage

FILE: rtl/core/gnh_square.sv
// ----------------------------------------------------------------------------
// gnh_square
// Registered squarer for one 25-bit magnitude, the shared arithmetic unit.
// ----------------------------------------------------------------------------
module gnh_square
  import gnh_pkg::*;
(
  input  logic    clk,
  input  sq_req_t req,
  output sq_t     sq
);

  always_ff @(posedge clk) begin
    if (req.start) begin
      sq <= sq_t'(req.a) * sq_t'(req.a);
    end
  end

endmodule

FILE: rtl/core/greedy_next_hop_neighbor_table_core.sv
// ----------------------------------------------------------------------------
// greedy_next_hop_neighbor_table_core
// Neighbor table with add, delete, lookup, purge, clear and greedy next hop.
// ----------------------------------------------------------------------------
// Channel  Direction  Signals
// in       input      in_valid, in_ready, command .. time_ms
// out      output     out_valid, out_ready, status .. out_vel_z
// cfg      APB        psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// Add, delete, lookups and purge read, then check, each slot in turn. Clear
// goes straight to the result word. Next hop first forms the self distance,
// then runs the purge scan, then forms each slot's distance on the one shared
// squarer.
// in_ready stays low from accept until the result word is taken, so a stalled
// receiver holds the block. Reset is synchronous; the table comes up empty.
module greedy_next_hop_neighbor_table_core
  import gnh_pkg::*;
#(
  parameter int NEIGHBORS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         command,
  input  logic [31:0]        address,
  input  logic signed [23:0] pos_x,
  input  logic signed [23:0] pos_y,
  input  logic signed [23:0] pos_z,
  input  logic signed [15:0] vel_x,
  input  logic signed [15:0] vel_y,
  input  logic signed [15:0] vel_z,
  input  logic signed [23:0] self_x,
  input  logic signed [23:0] self_y,
  input  logic signed [23:0] self_z,
  input  logic [31:0]        time_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [31:0]        next_hop,
  output logic signed [23:0] out_pos_x,
  output logic signed [23:0] out_pos_y,
  output logic signed [23:0] out_pos_z,
  output logic signed [15:0] out_vel_x,
  output logic signed [15:0] out_vel_y,
  output logic signed [15:0] out_vel_z,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int IW = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;
  localparam logic [IW-1:0] LAST = IW'(NEIGHBORS - 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SCAN   = 4'd1;  // issue slot read
  localparam logic [3:0] S_CHECK  = 4'd2;  // read data present
  localparam logic [3:0] S_FINISH = 4'd3;
  localparam logic [3:0] S_SELF   = 4'd4;  // self distance axes
  localparam logic [3:0] S_SQ     = 4'd5;  // issue slot read for distance
  localparam logic [3:0] S_ACC    = 4'd6;  // per-slot axes
  localparam logic [3:0] S_CMP    = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  // Slot memory, one row per slot.
  logic [31:0] mem_addr [NEIGHBORS];
  logic [23:0] mem_px   [NEIGHBORS];
  logic [23:0] mem_py   [NEIGHBORS];
  logic [23:0] mem_pz   [NEIGHBORS];
  logic [15:0] mem_vx   [NEIGHBORS];
  logic [15:0] mem_vy   [NEIGHBORS];
  logic [15:0] mem_vz   [NEIGHBORS];
  logic [31:0] mem_time [NEIGHBORS];

  logic [NEIGHBORS-1:0] valid;
  logic [31:0] lifetime;

  logic [3:0]    state;
  logic [IW-1:0] idx;
  logic [1:0]    axis;

  // Latched command.
  logic [2:0]  cmd;
  logic [31:0] key;
  logic [23:0] dpx, dpy, dpz, spx, spy, spz;
  logic [15:0] dvx, dvy, dvz;
  logic [31:0] now;

  // Read row.
  logic [31:0] r_addr, r_time;
  logic [23:0] r_px, r_py, r_pz;
  logic [15:0] r_vx, r_vy, r_vz;

  // Row of the matching slot, kept for a found lookup.
  logic [23:0] h_px, h_py, h_pz;
  logic [15:0] h_vx, h_vy, h_vz;

  logic          hit, free_found;
  logic [IW-1:0] hit_idx, free_idx;

  dist_t acc, self_d, best_d;
  logic  best_found;
  logic [31:0] best_addr;

  sq_req_t sq_req;
  sq_t     sq;

  gnh_square u_sq (.clk(clk), .req(sq_req), .sq(sq));

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? lifetime : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      lifetime <= LIFETIME_RESET;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      lifetime <= pwdata;
    end
  end

  assign in_ready = (state == S_IDLE) && !out_valid;

  // Squarer operand: difference of the current axis.
  logic signed [24:0] da, db, diff;
  always_comb begin
    if (state == S_SELF) begin
      case (axis)
        2'd0:    begin da = 25'(signed'(spx)); db = 25'(signed'(dpx)); end
        2'd1:    begin da = 25'(signed'(spy)); db = 25'(signed'(dpy)); end
        default: begin da = 25'(signed'(spz)); db = 25'(signed'(dpz)); end
      endcase
    end else begin
      case (axis)
        2'd0:    begin da = 25'(signed'(r_px)); db = 25'(signed'(dpx)); end
        2'd1:    begin da = 25'(signed'(r_py)); db = 25'(signed'(dpy)); end
        default: begin da = 25'(signed'(r_pz)); db = 25'(signed'(dpz)); end
      endcase
    end
    diff = da - db;
    sq_req.start = (state == S_SELF || state == S_ACC) && axis != 2'd3;
    sq_req.a     = diff[24] ? 25'(-diff) : 25'(diff);
  end

  // Expiry of the row just read, sum without wrap.
  logic [32:0] expire_sum;
  logic        expired;
  assign expire_sum = {1'b0, lifetime} + {1'b0, (r_addr == 32'd0) ? 32'd0 : r_time};
  assign expired    = expire_sum <= {1'b0, now};

  logic write_en;
  logic [IW-1:0] write_idx;

  always_ff @(posedge clk) begin
    if (state == S_SCAN || state == S_SQ) begin
      r_addr <= mem_addr[idx];
      r_time <= mem_time[idx];
      r_px   <= mem_px[idx];
      r_py   <= mem_py[idx];
      r_pz   <= mem_pz[idx];
      r_vx   <= mem_vx[idx];
      r_vy   <= mem_vy[idx];
      r_vz   <= mem_vz[idx];
    end
    if (write_en) begin
      mem_addr[write_idx] <= key;
      mem_time[write_idx] <= now;
      mem_px[write_idx]   <= dpx;
      mem_py[write_idx]   <= dpy;
      mem_pz[write_idx]   <= dpz;
      mem_vx[write_idx]   <= dvx;
      mem_vy[write_idx]   <= dvy;
      mem_vz[write_idx]   <= dvz;
    end
  end

  assign write_en  = (state == S_FINISH) && (cmd == CMD_ADD) && (hit || free_found);
  assign write_idx = hit ? hit_idx : free_idx;

  always_ff @(posedge clk) begin
    if (state == S_CHECK && valid[idx] && !hit && r_addr == key) begin
      h_px <= r_px; h_py <= r_py; h_pz <= r_pz;
      h_vx <= r_vx; h_vy <= r_vy; h_vz <= r_vz;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      valid     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            cmd <= command; key <= address; now <= time_ms;
            dpx <= pos_x; dpy <= pos_y; dpz <= pos_z;
            dvx <= vel_x; dvy <= vel_y; dvz <= vel_z;
            spx <= self_x; spy <= self_y; spz <= self_z;
            idx <= '0; axis <= 2'd0;
            hit <= 1'b0; free_found <= 1'b0;
            best_found <= 1'b0;
            if (command == CMD_CLEAR) begin
              state <= S_FINISH;
            end else if (command == CMD_NEXTHOP) begin
              state <= S_SELF;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (valid[idx]) begin
            if (cmd == CMD_PURGE || cmd == CMD_NEXTHOP) begin
              if (expired) valid[idx] <= 1'b0;
            end else if (!hit && r_addr == key) begin
              hit <= 1'b1; hit_idx <= idx;
            end
          end else if (!free_found) begin
            free_found <= 1'b1; free_idx <= idx;
          end
          if (idx == LAST) begin
            idx <= '0;
            state <= (cmd == CMD_NEXTHOP) ? S_SQ : S_FINISH;
          end else begin
            idx <= idx + IW'(1);
            state <= S_SCAN;
          end
        end
        S_SELF: begin
          // Square each axis in turn and accumulate; the last step adds the final square.
          if (axis == 2'd0) acc <= '0;
          else acc <= acc + dist_t'(sq);
          if (axis == 2'd3) begin
            self_d <= acc + dist_t'(sq);
            axis  <= 2'd0;
            state <= S_SCAN;
          end else begin
            axis <= axis + 2'd1;
          end
        end
        S_SQ: begin
          state <= S_ACC;
          axis  <= 2'd0;
          acc   <= '0;
        end
        S_ACC: begin
          if (axis != 2'd0) acc <= acc + dist_t'(sq);
          if (axis == 2'd3) begin
            state <= S_CMP;
          end else begin
            axis <= axis + 2'd1;
          end
        end
        S_CMP: begin
          if (valid[idx] && (!best_found || acc < best_d ||
              (acc == best_d && r_addr < best_addr))) begin
            best_found <= 1'b1; best_d <= acc; best_addr <= r_addr;
          end
          if (idx == LAST) begin
            state <= S_OUT;
          end else begin
            idx <= idx + IW'(1);
            state <= S_SQ;
          end
        end
        S_OUT: begin
          out_valid <= 1'b1;
          status    <= (best_found && self_d > best_d) ? ST_OK : ST_NOTFOUND;
          next_hop  <= (best_found && self_d > best_d) ? best_addr : 32'd0;
          out_pos_x <= '0; out_pos_y <= '0; out_pos_z <= '0;
          out_vel_x <= '0; out_vel_y <= '0; out_vel_z <= '0;
          state <= S_IDLE;
        end
        S_FINISH: begin
          out_valid <= 1'b1;
          next_hop  <= '0;
          status    <= ST_OK;
          out_pos_x <= (hit && cmd == CMD_GET_POS) ? h_px : 24'd0;
          out_pos_y <= (hit && cmd == CMD_GET_POS) ? h_py : 24'd0;
          out_pos_z <= (hit && cmd == CMD_GET_POS) ? h_pz : 24'd0;
          out_vel_x <= (hit && cmd == CMD_GET_VEL) ? h_vx : 16'd0;
          out_vel_y <= (hit && cmd == CMD_GET_VEL) ? h_vy : 16'd0;
          out_vel_z <= (hit && cmd == CMD_GET_VEL) ? h_vz : 16'd0;
          case (cmd) inside
            CMD_ADD: begin
              if (hit) valid[hit_idx] <= 1'b1;
              else if (free_found) valid[free_idx] <= 1'b1;
              else status <= ST_FULL;
            end
            CMD_DELETE: begin
              if (hit) valid[hit_idx] <= 1'b0;
              else status <= ST_NOTFOUND;
            end
            CMD_GET_POS, CMD_GET_VEL, CMD_IS_NBR: begin
              if (!hit) status <= ST_NOTFOUND;
            end
            CMD_CLEAR: valid <= '0;
            default: ;
          endcase
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE) else $error("ready outside idle");
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid) else $error("word dropped");
  a_word_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(status) && $stable(next_hop))
    else $error("word changed while stalled");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready) else $error("accepted while busy");
`endif

endmodule
